### design/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/mksc_pkg.sv
`default_nettype none

package mksc_pkg;

    // counter and register widths
    localparam int CNT_W     = 16;
    localparam int LIMIT_W   = 16;
    localparam int HOLD_W    = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int CMP_W     = 32;

    typedef logic [7:0]         t_sym;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [HOLD_W-1:0]  t_hold;

    // symbol codes
    localparam t_sym SYM_DOT      = 8'h2E;
    localparam t_sym SYM_DASH     = 8'h2D;
    localparam t_sym SYM_CHAR_END = 8'h23;
    localparam t_sym SYM_WORD_END = 8'h2F;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DOT_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 8'd3;

    // register reset values
    localparam t_limit RST_DOT_LIMIT = 16'd30;
    localparam t_limit RST_CHAR_GAP  = 16'd100;
    localparam t_limit RST_WORD_GAP  = 16'd200;
    localparam t_hold  RST_HOLDOFF   = 4'd2;

endpackage

`default_nettype wire

### design/morse_key_symbol_classifier.sv
// channel        dir  handshake                      payload
// s_axis         in   s_axis_tvalid/s_axis_tready    s_axis_tdata[0] key_down
// m_axis         out  m_axis_tvalid/m_axis_tready    m_axis_tdata[7:0] symbol_char
// cfg            in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// one word per cycle sustained while m_axis does not stall; a word waits in the
// input register, and its result (if any) is loaded into the output register
// the state update is a single pass of counter increments and compares
// synchronous active-low reset clears state, counters and flags, and loads
// the register defaults; a stalled m_axis holds back processing, the input
// register then fills and s_axis_tready drops
`default_nettype none

`include "assert_macros.svh"

module morse_key_symbol_classifier (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [0] key_down, [7:1] zero
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [7:0] symbol_char
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mksc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mksc_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import mksc_pkg::*;

    // configuration registers
    t_limit r_dot_limit;
    t_limit r_char_gap;
    t_limit r_word_gap;
    t_hold  r_holdoff;

    // input register
    logic r_in_valid;
    logic r_in_key;

    // classifier state
    t_cnt  r_press_cnt, n_press_cnt;
    t_cnt  r_idle_cnt,  n_idle_cnt;
    logic  r_key_held,  n_key_held;
    logic  r_char_done, n_char_done;
    logic  r_word_done, n_word_done;
    t_hold r_hold_left, n_hold_left;

    // output register
    logic r_out_valid;
    t_sym r_out_sym;
    logic n_emit;
    t_sym n_sym;

    logic proc_fire;
    logic in_fire;
    t_cnt idle_inc;

    assign o_cfg_ready   = 1'b1;
    assign proc_fire     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sym;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_limit <= RST_DOT_LIMIT;
            r_char_gap  <= RST_CHAR_GAP;
            r_word_gap  <= RST_WORD_GAP;
            r_holdoff   <= RST_HOLDOFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DOT_LIMIT: r_dot_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_CHAR_GAP:  r_char_gap  <= i_cfg_data[LIMIT_W-1:0];
                REG_WORD_GAP:  r_word_gap  <= i_cfg_data[LIMIT_W-1:0];
                REG_HOLDOFF:   r_holdoff   <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_key <= s_axis_tdata[0];
        end
    end

    // saturating idle increment
    assign idle_inc = (r_idle_cnt == '1) ? r_idle_cnt : r_idle_cnt + 1'b1;

    // per-tick state update
    always_comb begin
        n_press_cnt = r_press_cnt;
        n_idle_cnt  = r_idle_cnt;
        n_key_held  = r_key_held;
        n_char_done = r_char_done;
        n_word_done = r_word_done;
        n_hold_left = r_hold_left;
        n_emit      = 1'b0;
        n_sym       = SYM_CHAR_END;
        if (r_hold_left != '0) begin
            // debounce holdoff, key ignored
            n_hold_left = r_hold_left - 1'b1;
        end else if (r_in_key) begin
            // key down, count press ticks
            if (!r_key_held) begin
                n_press_cnt = t_cnt'(1);
            end else if (r_press_cnt != '1) begin
                n_press_cnt = r_press_cnt + 1'b1;
            end
            n_key_held = 1'b1;
        end else if (r_key_held) begin
            // release, classify the press
            n_emit      = 1'b1;
            n_sym       = (CMP_W'(r_press_cnt) < CMP_W'(r_dot_limit)) ? SYM_DOT : SYM_DASH;
            n_key_held  = 1'b0;
            n_press_cnt = '0;
            n_hold_left = r_holdoff;
            n_idle_cnt  = '0;
            n_char_done = 1'b0;
            n_word_done = 1'b0;
        end else begin
            // idle, word end first then character end
            n_idle_cnt = idle_inc;
            if ((CMP_W'(idle_inc) >= CMP_W'(r_word_gap)) && !r_word_done) begin
                n_emit      = 1'b1;
                n_sym       = SYM_WORD_END;
                n_word_done = 1'b1;
                n_char_done = 1'b1;
            end else if ((CMP_W'(idle_inc) >= CMP_W'(r_char_gap)) && !r_char_done) begin
                n_emit      = 1'b1;
                n_sym       = SYM_CHAR_END;
                n_char_done = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_cnt <= '0;
            r_idle_cnt  <= '0;
            r_key_held  <= 1'b0;
            r_char_done <= 1'b0;
            r_word_done <= 1'b0;
            r_hold_left <= '0;
        end else if (proc_fire) begin
            r_press_cnt <= n_press_cnt;
            r_idle_cnt  <= n_idle_cnt;
            r_key_held  <= n_key_held;
            r_char_done <= n_char_done;
            r_word_done <= n_word_done;
            r_hold_left <= n_hold_left;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= n_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && n_emit) begin
            r_out_sym <= n_sym;
        end
    end

    // checks
    `ASSERT_IMPL(a_word_implies_char, i_clk, i_rst_n, r_word_done, r_char_done)
    `ASSERT_IMPL(a_holdoff_not_held, i_clk, i_rst_n, r_hold_left != '0, !r_key_held)
    `ASSERT_NEXT(a_release_sym, i_clk, i_rst_n,
        proc_fire && !r_in_key && r_key_held && r_hold_left == '0,
        r_out_valid && (r_out_sym == SYM_DOT || r_out_sym == SYM_DASH))
    `ASSERT_NEXT(a_holdoff_silent, i_clk, i_rst_n,
        proc_fire && r_hold_left != '0,
        !r_out_valid && r_hold_left == $past(r_hold_left) - 1'b1)

endmodule

`default_nettype wire

### tb/morse_symbol_checker.sv
// watches the key, symbol and register channels of the classifier,
// keeps its own copy of the key timing state and checks every symbol word
module morse_symbol_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_key_valid,
    input  wire logic                           i_key_ready,
    input  wire logic [7:0]                     i_key_data,    // [0] key_down, [7:1] zero
    input  wire logic                           i_sym_valid,
    input  wire logic                           i_sym_ready,
    input  wire logic [7:0]                     i_sym_data,    // [7:0] symbol_char
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [mksc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mksc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_pending,
    output int                                  o_compared
);
    import mksc_pkg::*;

    localparam t_cnt CNT_TOP   = '1;
    localparam int   PRINT_CAP = 30;

    // register copy
    t_limit dot_limit;
    t_limit char_gap;
    t_limit word_gap;
    t_hold  holdoff;

    // key timing state
    t_cnt   press_count;
    t_cnt   idle_count;
    logic   key_held;
    logic   char_done;
    logic   word_done;
    t_hold  holdoff_left;

    // symbols still owed by the block, oldest first
    t_sym   owed_syms[$];
    int     mismatches = 0;
    int     compared   = 0;

    function automatic t_cnt bump(input t_cnt v);
        return (v == CNT_TOP) ? v : v + 1'b1;
    endfunction

    // advance the timing state by one key sample; returns 1 when a symbol comes out
    function automatic logic classify_tick(input logic down, output t_sym sym);
        sym = SYM_DOT;
        // debounce window swallows the sample
        if (holdoff_left != '0) begin
            holdoff_left = holdoff_left - 1'b1;
            return 1'b0;
        end
        if (down) begin
            press_count = key_held ? bump(press_count) : t_cnt'(1);
            key_held    = 1'b1;
            return 1'b0;
        end
        // release ends a press
        if (key_held) begin
            sym          = (press_count < dot_limit) ? SYM_DOT : SYM_DASH;
            key_held     = 1'b0;
            press_count  = '0;
            holdoff_left = holdoff;
            idle_count   = '0;
            char_done    = 1'b0;
            word_done    = 1'b0;
            return 1'b1;
        end
        // idle: word end wins over character end
        idle_count = bump(idle_count);
        if (idle_count >= word_gap && !word_done) begin
            word_done = 1'b1;
            char_done = 1'b1;
            sym       = SYM_WORD_END;
            return 1'b1;
        end
        if (idle_count >= char_gap && !char_done) begin
            char_done = 1'b1;
            sym       = SYM_CHAR_END;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report(input string what, input t_sym want, input t_sym got);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] %s: expected 8'h%02h, got 8'h%02h", $time, what, want, got);
        end
        mismatches++;
    endtask

    // channel monitor
    always @(posedge i_clk) begin : watch
        t_sym want;
        t_sym sym;
        if (!i_rst_n) begin
            dot_limit    = RST_DOT_LIMIT;
            char_gap     = RST_CHAR_GAP;
            word_gap     = RST_WORD_GAP;
            holdoff      = RST_HOLDOFF;
            press_count  = '0;
            idle_count   = '0;
            key_held     = 1'b0;
            char_done    = 1'b0;
            word_done    = 1'b0;
            holdoff_left = '0;
            owed_syms.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DOT_LIMIT: dot_limit = i_cfg_data[LIMIT_W-1:0];
                    REG_CHAR_GAP:  char_gap  = i_cfg_data[LIMIT_W-1:0];
                    REG_WORD_GAP:  word_gap  = i_cfg_data[LIMIT_W-1:0];
                    REG_HOLDOFF:   holdoff   = i_cfg_data[HOLD_W-1:0];
                    default:       ;
                endcase
            end
            // symbol words against the oldest owed symbol
            if (i_sym_valid && i_sym_ready) begin
                if (owed_syms.size() == 0) begin
                    report("symbol with none owed", '0, i_sym_data);
                end else begin
                    want = owed_syms.pop_front();
                    compared++;
                    if (want !== i_sym_data) begin
                        report("symbol mismatch", want, i_sym_data);
                    end
                end
            end
            // key samples
            if (i_key_valid && i_key_ready && classify_tick(i_key_data[0], sym)) begin
                owed_syms.push_back(sym);
            end
        end
        o_pending    <= owed_syms.size();
        o_mismatches <= mismatches;
        o_compared   <= compared;
    end

endmodule

### tb/tb_morse_key_symbol_classifier.sv
// stimulus and verdict for the morse key symbol classifier
module tb_morse_key_symbol_classifier;
    import mksc_pkg::*;

    localparam int     RESET_CYCLES  = 6;
    localparam longint LIMIT_TIME    = 16_000_000;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     TAIL_CYCLES   = 8;
    localparam int     LONG_TICKS    = 40;
    localparam int     PHASE_TICKS   = 150;
    localparam int     IDLE_HEAVY    = 85;
    localparam int     IDLE_BOTH     = 19;
    localparam t_limit LIMIT_MAX     = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 key_valid = 1'b0;
    logic                 key_ready;
    logic [7:0]           key_data  = '0;
    logic                 sym_valid;
    logic                 sym_ready = 1'b0;
    logic [7:0]           sym_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int ticks_sent     = 0;
    int settings_used  = 0;
    int cur_dl;
    int cur_cg;
    int cur_wg;
    int cur_ho;

    int mismatches;
    int pending;
    int compared;

    // clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    morse_key_symbol_classifier dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (key_valid),
        .s_axis_tready (key_ready),
        .s_axis_tdata  (key_data),
        .m_axis_tvalid (sym_valid),
        .m_axis_tready (sym_ready),
        .m_axis_tdata  (sym_data),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    morse_symbol_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_key_valid  (key_valid),
        .i_key_ready  (key_ready),
        .i_key_data   (key_data),
        .i_sym_valid  (sym_valid),
        .i_sym_ready  (sym_ready),
        .i_sym_data   (sym_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    // symbol receiver backpressure
    always @(posedge clk) begin
        sym_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one key sample word, with random sender gaps ahead of it
    task automatic send_tick(input logic down);
        while ($urandom_range(99) < send_idle_pct) begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_valid <= 1'b1;
        key_data  <= {7'b0, down};
        do @(posedge clk); while (!key_ready);
        ticks_sent++;
    endtask

    task automatic send_run(input logic down, input int n);
        repeat (n) send_tick(down);
    endtask

    // stop sending until every owed symbol is back, then let the pipe settle
    task automatic drain();
        key_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four registers with the block idle; junk also hits unused indexes
    task automatic apply_setting(input t_limit dl, input t_limit cg, input t_limit wg,
                                 input logic [CFG_DAT_W-1:0] ho_raw, input bit junk);
        logic [CFG_IDX_W-1:0] idx[$];
        logic [CFG_DAT_W-1:0] dat[$];
        drain();
        idx.push_back(REG_DOT_LIMIT); dat.push_back(dl);
        idx.push_back(REG_CHAR_GAP);  dat.push_back(cg);
        idx.push_back(REG_WORD_GAP);  dat.push_back(wg);
        idx.push_back(REG_HOLDOFF);   dat.push_back(ho_raw);
        if (junk) begin
            idx.push_back(REG_UNUSED_LOW);  dat.push_back(CFG_DAT_W'($urandom));
            idx.push_back(REG_UNUSED_HIGH); dat.push_back(CFG_DAT_W'($urandom));
        end
        foreach (idx[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= dat[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_dl = int'(dl);
        cur_cg = int'(cg);
        cur_wg = int'(wg);
        cur_ho = int'(ho_raw[HOLD_W-1:0]);
        settings_used++;
    endtask

    // one well-formed press: dot or dash, release, bouncy holdoff, then a gap
    task automatic key_symbol();
        int len;
        int gap;
        if (cur_dl > 1 && $urandom_range(1) == 1) begin
            len = $urandom_range(cur_dl - 1, 1);
        end else begin
            len = cur_dl + $urandom_range(4);
            if (len == 0) len = 1;
        end
        send_run(1'b1, len);
        send_tick(1'b0);
        for (int i = 0; i < cur_ho; i++) begin
            send_tick(($urandom_range(2) == 0) ? 1'b1 : 1'b0);
        end
        case ($urandom_range(2))
            0:       gap = $urandom_range(cur_cg - 1, 0);
            1:       gap = cur_cg + $urandom_range(3);
            default: gap = cur_wg + $urandom_range(6);
        endcase
        send_run(1'b0, gap);
    endtask

    // run limit
    initial begin
        #(LIMIT_TIME);
        $display("timeout with %0d symbols owed", pending);
        $display("morse_key_symbol_classifier regression: fail");
        $finish;
    end

    initial begin
        int phase_end;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: gap symbols before any press, dot/dash boundary at 30
        send_run(1'b0, 200);
        send_run(1'b1, 29);
        send_run(1'b0, 3);
        send_run(1'b1, 30);
        send_run(1'b0, 203);

        // small limits: dot, bounce in holdoff, dash, char end then word end once
        apply_setting(16'd2, 16'd3, 16'd5, 16'h0001, 1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_run(1'b1, 2);
        send_tick(1'b0);
        send_run(1'b0, 7);

        // zero limits and no holdoff: every press a dash, word end on first idle tick
        apply_setting(16'd0, 16'd0, 16'd0, 16'hFFF0, 1'b1);
        send_tick(1'b1);
        send_run(1'b0, 3);
        send_tick(1'b1);
        send_tick(1'b0);

        // word gap below char gap, longest holdoff full of bounces
        apply_setting(16'd1, 16'd4, 16'd2, 16'h000F, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        for (int i = 0; i < 15; i++) send_tick(1'(i));
        send_run(1'b0, 6);

        // largest limits: a long press stays a dot and no gap symbol comes
        apply_setting(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 16'hFFFF, 1'b0);
        send_run(1'b1, LONG_TICKS);
        send_run(1'b0, LONG_TICKS);

        // random key traffic under random settings and flow-control mixes
        for (int p = 0; p < 8; p++) begin
            apply_setting(($urandom_range(9) == 0) ? t_limit'($urandom_range(1))
                                                   : t_limit'($urandom_range(8, 2)),
                          t_limit'($urandom_range(12, 2)),
                          t_limit'($urandom_range(24, 1)),
                          CFG_DAT_W'($urandom), 1'b0);
            case (p / 2)
                0: begin send_idle_pct = 0;          recv_stall_pct = 0;          end
                1: begin send_idle_pct = IDLE_HEAVY; recv_stall_pct = 0;          end
                2: begin send_idle_pct = 0;          recv_stall_pct = IDLE_HEAVY; end
                default: begin send_idle_pct = IDLE_BOTH; recv_stall_pct = IDLE_BOTH; end
            endcase
            phase_end = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_end) begin
                if ($urandom_range(99) < 80) begin
                    key_symbol();
                end else begin
                    repeat ($urandom_range(12, 1)) send_tick(1'($urandom_range(1)));
                end
                if ($urandom_range(49) == 0) drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d key samples over %0d register settings and four flow-control mixes",
                 ticks_sent, settings_used);
        $display("%0d symbols compared, %0d mismatches, %0d still owed",
                 compared, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("morse_key_symbol_classifier regression: pass");
        end else begin
            $display("morse_key_symbol_classifier regression: fail");
        end
        $finish;
    end

endmodule
